[src/pfr_pkg.sv]
// Shared types and constants for the Pareto front ranker.
package pfr_pkg;

  localparam int MAX_POP_DEF = 64;
  localparam int MAX_OBJ_DEF = 4;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = 6;
  localparam int RANK_W      = 6;
  localparam int NOBJ_W      = 3;
  localparam int FIFO_DEPTH  = 4;

  typedef struct packed {
    logic signed [KEY_W-1:0] obj_0;
    logic signed [KEY_W-1:0] obj_1;
    logic signed [KEY_W-1:0] obj_2;
    logic signed [KEY_W-1:0] obj_3;
    logic                    last_individual;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  individual_index;
    logic [RANK_W-1:0] front_rank;
    logic              last_result;
  } result_t;

  // front queue to back end
  typedef struct packed {
    logic  valid;
    item_t data;
  } fifo_out_t;

endpackage

[src/pareto_front_ranker.sv]
// Top level of the Pareto front ranker: item queue, sorter, config register.
//
//   channel   handshake             payload
//   item      start / busy          item   (item_t)
//   result    result_valid strobe   result (result_t)
//   config    cfg_valid / cfg_ready cfg_data (num_objectives)
//
// Loading takes one item per cycle into a four-deep queue; busy rises when it is full.
// The sorter scan loop does one store read and one compare per cycle.
// Items queued during a sort wait and load once it is done.
// Reset is synchronous; results cannot be held off by the receiver.
module pareto_front_ranker
  import pfr_pkg::*;
#(
  parameter int MAX_POP = MAX_POP_DEF,
  parameter int MAX_OBJ = MAX_OBJ_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  item_t             item,
  output logic              result_valid,
  output result_t           result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [NOBJ_W-1:0] cfg_data
);

  logic [NOBJ_W-1:0] num_objectives;
  fifo_out_t         fifo_head;
  logic              fifo_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_objectives <= NOBJ_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      num_objectives <= cfg_data;
    end
  end

  pfr_item_fifo u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (start),
    .push_data (item),
    .full      (busy),
    .pop       (fifo_pop),
    .head      (fifo_head)
  );

  pfr_sorter #(.MAX_POP(MAX_POP), .MAX_OBJ(MAX_OBJ)) u_back (
    .clk       (clk),
    .rst       (rst),
    .num_obj   (num_objectives),
    .head      (fifo_head),
    .pop       (fifo_pop),
    .res_valid (result_valid),
    .res       (result)
  );

endmodule

[src/pfr_ram.sv]
// Generic single write port, single read port RAM with registered read.
module pfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/pfr_item_fifo.sv]
// Front end: accepts items into a short queue ahead of the sorter.
module pfr_item_fifo
  import pfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     push_data,
  output logic      full,
  input  logic      pop,
  output fifo_out_t head
);

  localparam int PW = $clog2(FIFO_DEPTH);

  item_t        slots [FIFO_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign full = (count == (PW+1)'(FIFO_DEPTH));
  assign head = {(count != '0), slots[rptr]};

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_data;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + PW'(1);
      end
      if (pop && head.valid) begin
        rptr <= rptr + PW'(1);
      end
      count <= count + (PW+1)'(push && !full) - (PW+1)'(pop && head.valid);
    end
  end

endmodule

[src/pfr_sorter.sv]
// Back end: loads objectives into the store and walks the fronts.
module pfr_sorter
  import pfr_pkg::*;
#(
  parameter int MAX_POP = MAX_POP_DEF,
  parameter int MAX_OBJ = MAX_OBJ_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [NOBJ_W-1:0] num_obj,
  input  fifo_out_t         head,
  output logic              pop,
  output logic              res_valid,
  output result_t           res
);

  localparam int IW = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
  localparam int CW = $clog2(MAX_POP + 1);
  localparam int OW = MAX_OBJ * KEY_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HEAD = 5'b00010,
    S_HLAT = 5'b00100,
    S_SCAN = 5'b01000,
    S_NEXT = 5'b10000
  } state_t;

  state_t              state;
  logic [CW-1:0]       loaded, n, h, j, dcount, produced;
  logic [RANK_W-1:0]   front;
  logic [NOBJ_W-1:0]   m;
  logic [MAX_POP-1:0]  pending, flag;
  logic                rd_v;
  logic [IW-1:0]       rd_idx;
  logic [OW-1:0]       head_obj, rdata, wdata;
  logic [IW-1:0]       raddr;
  logic                we, dom;
  logic [KEY_W-1:0]    keys [4];
  logic [CW-1:0]       n_next;
  logic [NOBJ_W-1:0]   m_next;

  assign keys[0] = head.data.obj_0;
  assign keys[1] = head.data.obj_1;
  assign keys[2] = head.data.obj_2;
  assign keys[3] = head.data.obj_3;

  always_comb begin
    for (int k = 0; k < MAX_OBJ; k++) begin
      wdata[k*KEY_W +: KEY_W] = keys[k];
    end
  end

  assign pop    = (state == S_IDLE) && head.valid;
  assign we     = pop && (loaded < CW'(MAX_POP));
  assign n_next = loaded + CW'(we);

  always_comb begin
    if (num_obj == '0) begin
      m_next = NOBJ_W'(1);
    end else if (num_obj > NOBJ_W'(MAX_OBJ)) begin
      m_next = NOBJ_W'(MAX_OBJ);
    end else begin
      m_next = num_obj;
    end
  end

  assign raddr = (state == S_SCAN) ? j[IW-1:0] : h[IW-1:0];

  pfr_ram #(.WIDTH(OW), .DEPTH(MAX_POP)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (loaded[IW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // head weakly dominates the entry just read
  always_comb begin
    dom = 1'b1;
    for (int k = 0; k < MAX_OBJ; k++) begin
      if (NOBJ_W'(k) < m &&
          $signed(head_obj[k*KEY_W +: KEY_W]) > $signed(rdata[k*KEY_W +: KEY_W])) begin
        dom = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HLAT) begin
      head_obj             <= rdata;
      res.individual_index <= IDX_W'(h);
      res.front_rank       <= front;
      res.last_result      <= (produced + CW'(1) == n);
    end
    if (rst) begin
      res_valid <= 1'b0;
      state    <= S_IDLE;
      loaded   <= '0;
      n        <= '0;
      h        <= '0;
      j        <= '0;
      dcount   <= '0;
      produced <= '0;
      front    <= '0;
      m        <= NOBJ_W'(2);
      pending  <= '0;
      flag     <= '0;
      rd_v     <= 1'b0;
      rd_idx   <= '0;
    end else begin
      res_valid <= (state == S_HLAT);
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            loaded <= n_next;
            if (head.data.last_individual) begin
              n        <= n_next;
              m        <= m_next;
              h        <= '0;
              front    <= '0;
              produced <= '0;
              dcount   <= '0;
              flag     <= '0;
              for (int i = 0; i < MAX_POP; i++) begin
                pending[i] <= (CW'(i) < n_next);
              end
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          if (h == n) begin
            state <= S_NEXT;
          end else if (pending[h[IW-1:0]]) begin
            state <= S_HLAT;
          end else begin
            h <= h + CW'(1);
          end
        end
        S_HLAT: begin
          produced             <= produced + CW'(1);
          pending[h[IW-1:0]]   <= 1'b0;
          j                    <= h + CW'(1);
          rd_v                 <= 1'b0;
          state                <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_v && dom) begin
            pending[rd_idx] <= 1'b0;
            flag[rd_idx]    <= 1'b1;
            dcount          <= dcount + CW'(1);
          end
          if (j < n) begin
            rd_v   <= pending[j[IW-1:0]];
            rd_idx <= j[IW-1:0];
            j      <= j + CW'(1);
          end else begin
            rd_v <= 1'b0;
            if (!rd_v) begin
              h     <= h + CW'(1);
              state <= S_HEAD;
            end
          end
        end
        S_NEXT: begin
          if (dcount == '0) begin
            loaded <= '0;
            state  <= S_IDLE;
          end else begin
            pending <= flag;
            flag    <= '0;
            dcount  <= '0;
            front   <= front + RANK_W'(1);
            h       <= '0;
            state   <= S_HEAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/tb.sv]
// Testbench for pareto_front_ranker: queued stimulus, front-sort prediction, result checking.
module tb;
  import pfr_pkg::*;

  localparam int LIMIT = 200000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  item_t             item = '0;
  logic              result_valid;
  result_t           result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [NOBJ_W-1:0] cfg_data = '0;

  pareto_front_ranker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  item_t             item_q[$];
  result_t           rank_q[$];
  logic signed [31:0] keys[MAX_POP_DEF][MAX_OBJ_DEF];
  int                loaded = 0;
  logic [NOBJ_W-1:0] nobj = 3'd2;
  int                idle_pct = 0;
  int                errors = 0;
  int                quiet = 0;
  bit                took = 1'b0;

  function automatic bit weakly_dominates(int a, int b, int m);
    for (int k = 0; k < m; k++)
      if (keys[a][k] > keys[b][k]) return 1'b0;
    return 1'b1;
  endfunction

  // load one individual; on the last flag, peel off fronts and queue the ranks
  function automatic void rank_population(item_t it);
    int m;
    int rank;
    int open_q[$];
    int keep[$];
    bit dom[MAX_POP_DEF];
    int head;
    result_t r;
    if (loaded < MAX_POP_DEF) begin
      keys[loaded][0] = it.obj_0;
      keys[loaded][1] = it.obj_1;
      keys[loaded][2] = it.obj_2;
      keys[loaded][3] = it.obj_3;
      loaded++;
    end
    if (!it.last_individual) return;
    m = (nobj < 1) ? 1 : (nobj > MAX_OBJ_DEF) ? MAX_OBJ_DEF : int'(nobj);
    rank = 0;
    for (int i = 0; i < loaded; i++) open_q.insert(open_q.size(), i);
    while (open_q.size() > 0) begin
      dom = '{default: 1'b0};
      while (open_q.size() > 0) begin
        head = open_q[0];
        open_q.delete(0);
        r.individual_index = head[IDX_W-1:0];
        r.front_rank = rank[RANK_W-1:0];
        r.last_result = 1'b0;
        rank_q.insert(rank_q.size(), r);
        keep.delete();
        foreach (open_q[i])
          if (weakly_dominates(head, open_q[i], m)) dom[open_q[i]] = 1'b1;
          else keep.insert(keep.size(), open_q[i]);
        open_q = keep;
      end
      for (int i = 0; i < loaded; i++) if (dom[i]) open_q.insert(open_q.size(), i);
      rank++;
    end
    rank_q[rank_q.size()-1].last_result = 1'b1;
    loaded = 0;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (item_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        item <= item_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    result_t want;
    item_t   got;
    if (!rst) begin
      took = start && !busy;
      if (took) begin
        got = item_q[0];
        item_q.delete(0);
        rank_population(got);
        quiet = 0;
      end
      if (result_valid) begin
        quiet = 0;
        if (rank_q.size() == 0) begin
          $error("unexpected result index %0d rank %0d",
                 result.individual_index, result.front_rank);
          errors++;
        end else begin
          want = rank_q[0];
          rank_q.delete(0);
          if (result.individual_index !== want.individual_index) begin
            $error("individual_index expected %0d actual %0d",
                   want.individual_index, result.individual_index);
            errors++;
          end
          if (result.front_rank !== want.front_rank) begin
            $error("front_rank expected %0d actual %0d", want.front_rank, result.front_rank);
            errors++;
          end
          if (result.last_result !== want.last_result) begin
            $error("last_result expected %0d actual %0d", want.last_result, result.last_result);
            errors++;
          end
        end
      end else if (!took) begin
        quiet++;
        if (quiet >= LIMIT) begin
          $display("FAIL pareto_front_ranker");
          $finish;
        end
      end
    end
  end

  function automatic logic signed [31:0] pick_key(int style);
    logic signed [31:0] v;
    case (style)
      0: v = $urandom_range(6) - 3;
      1: v = $urandom;
      default: begin
        case ($urandom_range(3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic push_item(logic signed [31:0] a, logic signed [31:0] b,
                           logic signed [31:0] c, logic signed [31:0] d, bit last);
    item_t it;
    it.obj_0 = a;
    it.obj_1 = b;
    it.obj_2 = c;
    it.obj_3 = d;
    it.last_individual = last;
    item_q.insert(item_q.size(), it);
  endtask

  task automatic push_population(int n, int style);
    int s;
    for (int i = 0; i < n; i++) begin
      s = (style < 0) ? $urandom_range(2) : style;
      push_item(pick_key(s), pick_key(s), pick_key(s), pick_key(s), i == n - 1);
    end
  endtask

  // sender holds off until every rank is back and the sorter has settled
  task automatic drain();
    wait (item_q.size() == 0 && rank_q.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_nobj(logic [NOBJ_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    nobj = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int total;
    int p;
    int pops;
    int n;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed: extremes, equal points, out-of-range objective counts
    push_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    push_item(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    push_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    push_item(0, 0, 0, 0, 1'b0);
    push_item(0, 0, 0, 0, 1'b0);
    push_item(-1, 1, -1, 1, 1'b1);
    drain();
    write_nobj(3'd1);
    push_population(4, 2);
    drain();
    write_nobj(3'd4);
    push_item(1, 2, 3, 4, 1'b0);
    push_item(1, 2, 3, 5, 1'b0);
    push_item(1, 2, 3, 4, 1'b0);
    push_item(2, 1, 3, 4, 1'b1);
    drain();
    write_nobj(3'd0);
    push_population(3, 0);
    drain();
    write_nobj(3'd7);
    push_population(3, 0);
    drain();
    write_nobj(3'd3);
    push_population(3, 2);
    drain();
    total = 23;

    p = 0;
    while (total < 380) begin
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 88;
        2: idle_pct = 27;
        default: idle_pct = 0;
      endcase
      write_nobj(3'($urandom_range(7)));
      pops = $urandom_range(1, 3);
      for (int i = 0; i < pops; i++) begin
        if (p == 3 && i == 0) n = 64;
        else if (p == 7 && i == 0) n = 66;
        else n = $urandom_range(2, 12);
        push_population(n, -1);
        total += n;
      end
      drain();
      p++;
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && rank_q.size() == 0) begin
      $display("PASS pareto_front_ranker");
    end else begin
      $display("FAIL pareto_front_ranker");
    end
    $finish;
  end

endmodule

[filelist.f]
src/pfr_pkg.sv
src/pfr_ram.sv
src/pfr_item_fifo.sv
src/pfr_sorter.sv
src/pareto_front_ranker.sv
tb/tb.sv
